>>> hw/rtl/cbb_pkg.sv
`timescale 1ns / 1ps

package cbb_pkg;

  // Width of the reported line and column fields
  localparam int OUT_POS_W = 16;

  // Result codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_PAREN    = 3'd1,
    ST_CURLY    = 3'd2,
    ST_SQUARE   = 3'd3,
    ST_QUOTE    = 3'd4,
    ST_UNCLOSED = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

endpackage

>>> hw/rtl/cbb_if.sv
`timescale 1ns / 1ps

// Text byte channel
interface cbb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_byte;

  modport source (output valid, output char_code, output last_byte, input ready);
  modport sink   (input valid, input char_code, input last_byte, output ready);
endinterface

// Check result channel
interface cbb_result_if;
  logic                            valid;
  logic                            ready;
  cbb_pkg::status_t                status;
  logic [cbb_pkg::OUT_POS_W-1:0]   line_number;
  logic [cbb_pkg::OUT_POS_W-1:0]   column_number;

  modport source (output valid, output status, output line_number, output column_number,
                  input ready);
  modport sink   (input valid, input status, input line_number, input column_number,
                  output ready);
endinterface

>>> hw/rtl/cbb_ram.sv
`timescale 1ns / 1ps

module cbb_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/c_bracket_balance_checker.sv
`timescale 1ns / 1ps

// Bracket balance checker for C source text. It takes one byte per clock cycle
// with no gaps of its own; the result word for a byte is registered into a
// two-word output queue, and input stalls only when both queue slots hold words
// the sink has not taken. The open-entry stack keeps its top entry in flip-flops
// and the entries below in a single-port-write RAM with a registered read; the
// entry under the top is read ahead every cycle (and forwarded after a push), so
// a pop is ready at once and the stack sustains one push or pop per cycle.
// A text produces exactly one word: the first error (mismatched closer, newline
// inside a quote, stack overflow) at its position (the opening quote's for a
// newline in a quote), or at the last byte that of the innermost still-open
// entry, or status OK with zero position. After an error the rest of the text
// is consumed silently up to and including its last byte. No clearing pass is
// needed after reset; the block is ready in the first cycle.
module c_bracket_balance_checker #(
  parameter int STACK_DEPTH   = 64,
  parameter int POSITION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  cbb_byte_if.sink        text,
  cbb_result_if.source    report
);

  localparam int HW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = POSITION_BITS;
  localparam int OW = cbb_pkg::OUT_POS_W;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_START   = 8'h46;

  typedef enum logic [2:0] {
    TAG_NONE    = 3'd0,
    TAG_PAREN   = 3'd1,
    TAG_CURLY   = 3'd2,
    TAG_SQUARE  = 3'd3,
    TAG_SQUOTE  = 3'd4,
    TAG_DQUOTE  = 3'd5,
    TAG_COMMENT = 3'd6
  } tag_t;

  typedef struct packed {
    tag_t          tag;
    logic [PW-1:0] line;
    logic [PW-1:0] col;
  } entry_t;

  typedef struct packed {
    cbb_pkg::status_t status;
    logic [OW-1:0]    line;
    logic [OW-1:0]    col;
  } result_t;

  localparam int EW = $bits(entry_t);

  // Clamp a position to the width of the result fields
  function automatic logic [OW-1:0] clamp_pos(input logic [PW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    clamp_pos = (|w[31:OW]) ? '1 : w[OW-1:0];
  endfunction

  // Core state
  logic [HW-1:0] height, height_next;
  entry_t        top, top_next;
  logic [PW-1:0] cur_line, cur_line_next;
  logic [PW-1:0] cur_col, cur_col_next;
  logic [7:0]    prev_byte, prev_byte_next;
  logic          esc, esc_next;
  logic          in_comment, in_comment_next;
  logic          err_rep, err_rep_next;
  logic          byp;
  entry_t        byp_data;

  // Output queue
  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    res_valid;
  result_t res;

  // RAM port signals
  logic          wr_en;
  logic          rd_en;
  logic [HW-1:0] rd_height;
  logic [EW-1:0] rd_data;
  entry_t        below;

  // Decode signals
  logic             accept, last;
  logic [7:0]       c;
  logic [PW-1:0]    col_inc, line_inc;
  logic             full, has_top;
  tag_t             top_tag;
  logic             in_dq, in_sq, free;
  logic             push_req, pop_req, esc_req, nl_step, quote_err;
  tag_t             push_tag;
  cbb_pkg::status_t close_err, err_code;
  logic             overflow, has_err, do_push, step;

  assign text.ready = !skid_valid;
  assign accept     = text.valid && text.ready;
  assign c          = text.char_code;
  assign last       = text.last_byte;

  assign col_inc  = (cur_col == '1) ? cur_col : cur_col + PW'(1);
  assign line_inc = (cur_line == '1) ? cur_line : cur_line + PW'(1);
  assign full     = (height == HW'(STACK_DEPTH));
  assign has_top  = (height != '0);
  assign top_tag  = has_top ? top.tag : TAG_NONE;
  assign in_dq    = (top_tag == TAG_DQUOTE);
  assign in_sq    = (top_tag == TAG_SQUOTE);
  assign free     = !in_dq && !in_sq;
  assign below    = byp ? byp_data : entry_t'(rd_data);

  // Classify the byte against the current context
  always_comb begin
    push_req  = 1'b0;
    push_tag  = TAG_NONE;
    pop_req   = 1'b0;
    esc_req   = 1'b0;
    nl_step   = 1'b0;
    quote_err = 1'b0;
    close_err = cbb_pkg::ST_OK;
    if (esc) begin
      nl_step = (c == CH_NL);
    end else begin
      unique case (c)
        CH_SLASH: begin
          if (free && prev_byte == CH_SLASH && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_COMMENT;
          end
        end
        CH_LPAREN: begin
          if (free && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_PAREN;
          end
        end
        CH_LCURLY: begin
          if (free && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_CURLY;
          end
        end
        CH_LSQUARE: begin
          if (free && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_SQUARE;
          end
        end
        CH_RPAREN: begin
          if (free && !in_comment) begin
            if (top_tag != TAG_PAREN) close_err = cbb_pkg::ST_PAREN;
            else pop_req = 1'b1;
          end
        end
        CH_RCURLY: begin
          if (free && !in_comment) begin
            if (top_tag != TAG_CURLY) close_err = cbb_pkg::ST_CURLY;
            else pop_req = 1'b1;
          end
        end
        CH_RSQUARE: begin
          if (free && !in_comment) begin
            if (top_tag != TAG_SQUARE) close_err = cbb_pkg::ST_SQUARE;
            else pop_req = 1'b1;
          end
        end
        CH_DQUOTE: begin
          if (free && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_DQUOTE;
          end else if (in_dq) begin
            pop_req = 1'b1;
          end
        end
        CH_SQUOTE: begin
          if (free && !in_comment) begin
            push_req = 1'b1;
            push_tag = TAG_SQUOTE;
          end else if (in_sq) begin
            pop_req = 1'b1;
          end
        end
        CH_BSLASH: begin
          if (!in_comment) esc_req = 1'b1;
        end
        CH_NL: begin
          if (in_dq || in_sq) begin
            quote_err = 1'b1;
          end else begin
            nl_step = 1'b1;
            if (in_comment) pop_req = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Pick the error code, if any
  assign overflow = (push_req || esc_req) && full;
  always_comb begin
    priority if (overflow) err_code = cbb_pkg::ST_OVERFLOW;
    else if (quote_err)    err_code = cbb_pkg::ST_QUOTE;
    else                   err_code = close_err;
  end
  assign has_err = (err_code != cbb_pkg::ST_OK);
  assign do_push = push_req && !full;
  assign step    = accept && !err_rep;

  // Next state and result word
  always_comb begin
    height_next     = height;
    top_next        = top;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    prev_byte_next  = prev_byte;
    esc_next        = esc;
    in_comment_next = in_comment;
    err_rep_next    = err_rep;
    res_valid       = 1'b0;
    res.status      = cbb_pkg::ST_OK;
    res.line        = '0;
    res.col         = '0;
    if (step) begin
      prev_byte_next = c;
      cur_col_next   = col_inc;
      if (has_err) begin
        res_valid    = 1'b1;
        res.status   = err_code;
        res.line     = quote_err ? clamp_pos(top.line) : clamp_pos(cur_line);
        res.col      = quote_err ? clamp_pos(top.col) : clamp_pos(col_inc);
        err_rep_next = 1'b1;
      end else begin
        if (nl_step) begin
          cur_col_next  = '0;
          cur_line_next = line_inc;
        end
        esc_next = esc_req;
        if (do_push) begin
          top_next.tag  = push_tag;
          top_next.line = cur_line;
          top_next.col  = col_inc;
          height_next   = height + HW'(1);
          if (push_tag == TAG_COMMENT) in_comment_next = 1'b1;
        end else if (pop_req) begin
          top_next    = below;
          height_next = height - HW'(1);
          if (nl_step) in_comment_next = 1'b0;
        end
        if (last) begin
          res_valid = 1'b1;
          if (height_next != '0) begin
            res.status = cbb_pkg::ST_UNCLOSED;
            res.line   = clamp_pos(top_next.line);
            res.col    = clamp_pos(top_next.col);
          end
        end
      end
    end
    // Start over on a fresh text after its last byte
    if (accept && last) begin
      height_next     = '0;
      cur_line_next   = PW'(1);
      cur_col_next    = '0;
      prev_byte_next  = CH_START;
      esc_next        = 1'b0;
      in_comment_next = 1'b0;
      err_rep_next    = 1'b0;
    end
  end

  // Spill the old top below on a push; read ahead the entry under the new top
  assign wr_en     = step && !has_err && do_push && has_top;
  assign rd_height = height_next - HW'(2);
  assign rd_en     = (height_next >= HW'(2));

  cbb_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(height - HW'(1))),
    .wr_data (EW'(top)),
    .rd_en   (rd_en),
    .rd_addr (rd_height[AW-1:0]),
    .rd_data (rd_data)
  );

  // Hold core state
  always_ff @(posedge clk) begin
    if (rst) begin
      height     <= '0;
      cur_line   <= PW'(1);
      cur_col    <= '0;
      prev_byte  <= CH_START;
      esc        <= 1'b0;
      in_comment <= 1'b0;
      err_rep    <= 1'b0;
      byp        <= 1'b0;
    end else begin
      height     <= height_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      prev_byte  <= prev_byte_next;
      esc        <= esc_next;
      in_comment <= in_comment_next;
      err_rep    <= err_rep_next;
      byp        <= wr_en;
    end
  end

  // Top entry and forwarded spill word carry no reset
  always_ff @(posedge clk) begin
    top      <= top_next;
    byp_data <= top;
  end

  // Advance the two-word output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || report.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= res_valid;
        skid_data  <= res;
      end else begin
        out_valid <= res_valid;
        out_data  <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= res;
    end
  end

  assign report.valid         = out_valid;
  assign report.status        = out_data.status;
  assign report.line_number   = out_data.line;
  assign report.column_number = out_data.col;

endmodule

>>> hw/rtl/cbb_checker.sv
`timescale 1ns / 1ps

module cbb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input cbb_pkg::status_t              status,
  input logic [cbb_pkg::OUT_POS_W-1:0] line_number,
  input logic [cbb_pkg::OUT_POS_W-1:0] column_number
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(line_number)
      && $stable(column_number))
    else $error("stalled result word changed");

  // Drop any result word on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // A clean text reports a zero position
  a_ok_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cbb_pkg::ST_OK |-> line_number == '0 && column_number == '0)
    else $error("ok result with nonzero position");

  // Every error position lies on a real line
  a_err_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cbb_pkg::ST_OK |-> line_number != '0)
    else $error("error result on line zero");

  // Hold off a text word only while a result word waits
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("text word held off with no result word waiting");

endmodule

bind c_bracket_balance_checker cbb_checker u_cbb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (text.valid),
  .in_ready      (text.ready),
  .out_valid     (report.valid),
  .out_ready     (report.ready),
  .status        (report.status),
  .line_number   (report.line_number),
  .column_number (report.column_number)
);
